/* design/pcsm_pkg.sv */
// Package for the Python comment and string masker: lexer modes, character codes, shared types.
`default_nettype none
package pcsm_pkg;

    // Lexer modes; codes 6 and 7 are unused and behave as code mode
    typedef enum logic [2:0] {
        LEX_CODE    = 3'd0,
        LEX_COMMENT = 3'd1,
        LEX_OPEN1   = 3'd2,
        LEX_AFTER2  = 3'd3,
        LEX_SINGLE  = 3'd4,
        LEX_TRIPLE  = 3'd5
    } lex_mode_t;

    // Character codes
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;

    // Quote kind encoding
    localparam logic QK_SINGLE = 1'b0;
    localparam logic QK_DOUBLE = 1'b1;

    // Triple-quote closing run: third matching quote closes
    localparam logic [1:0] RUN_CLOSE = 2'd2;

    // One step of the lexer, handed from the input stage
    typedef struct packed {
        logic       step;
        logic [7:0] text_byte;
        logic       first_byte;
    } lex_step_t;

endpackage : pcsm_pkg
`default_nettype wire

/* design/pcsm_lexer.sv */
// Lexer state machine: mode, quote kind, escape flag and quote run, plus per-byte code flag.
`default_nettype none
module pcsm_lexer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pcsm_pkg::lex_step_t lex_in,
    output logic                   is_code
);
    import pcsm_pkg::*;

    lex_mode_t  mode_reg, mode_next;
    logic       kind_reg, kind_next;
    logic       esc_reg, esc_next;
    logic [1:0] run_reg, run_next;

    // State as seen by this byte: a new text starts in code mode
    lex_mode_t  cur_mode;
    logic       cur_kind;
    logic       cur_esc;
    logic [1:0] cur_run;
    logic [7:0] c;
    logic       is_q;
    logic       is_bs;
    logic       is_nl;
    logic       is_hash;
    logic       is_anyq;

    // Code-mode handling of a byte
    lex_mode_t  code_mode;
    logic       code_kind;
    logic       code_res;

    assign c        = lex_in.text_byte;
    assign cur_mode = lex_in.first_byte ? LEX_CODE  : mode_reg;
    assign cur_kind = lex_in.first_byte ? QK_SINGLE : kind_reg;
    assign cur_esc  = lex_in.first_byte ? 1'b0      : esc_reg;
    assign cur_run  = lex_in.first_byte ? 2'd0      : run_reg;

    assign is_q    = (c == ((cur_kind == QK_DOUBLE) ? CH_DQUOTE : CH_SQUOTE));
    assign is_bs   = (c == CH_BSLASH);
    assign is_nl   = (c == CH_NL);
    assign is_hash = (c == CH_HASH);
    assign is_anyq = (c == CH_SQUOTE) || (c == CH_DQUOTE);

    // Code-mode decode: hash opens a comment, a quote opens a string
    always_comb
    begin
        code_kind = cur_kind;
        priority if (is_hash)
        begin
            code_mode = LEX_COMMENT;
            code_res  = 1'b0;
        end
        else if (is_anyq)
        begin
            code_mode = LEX_OPEN1;
            code_kind = (c == CH_DQUOTE) ? QK_DOUBLE : QK_SINGLE;
            code_res  = 1'b0;
        end
        else
        begin
            code_mode = LEX_CODE;
            code_res  = 1'b1;
        end
    end

    // Next state
    always_comb
    begin
        mode_next = cur_mode;
        kind_next = cur_kind;
        esc_next  = cur_esc;
        run_next  = cur_run;
        unique case (cur_mode)
            LEX_COMMENT:
            begin
                if (is_nl)
                begin
                    mode_next = LEX_CODE;
                end
            end
            LEX_OPEN1:
            begin
                priority if (is_q)
                begin
                    mode_next = LEX_AFTER2;
                end
                else if (is_bs)
                begin
                    esc_next  = 1'b1;
                    mode_next = LEX_SINGLE;
                end
                else if (is_nl)
                begin
                    mode_next = LEX_CODE;
                end
                else
                begin
                    mode_next = LEX_SINGLE;
                end
            end
            LEX_AFTER2:
            begin
                if (is_q)
                begin
                    mode_next = LEX_TRIPLE;
                    run_next  = 2'd0;
                    esc_next  = 1'b0;
                end
                else
                begin
                    mode_next = code_mode;
                    kind_next = code_kind;
                    esc_next  = 1'b0;
                    run_next  = 2'd0;
                end
            end
            LEX_SINGLE:
            begin
                priority if (cur_esc)
                begin
                    esc_next = 1'b0;
                end
                else if (is_bs)
                begin
                    esc_next = 1'b1;
                end
                else if (is_q || is_nl)
                begin
                    mode_next = LEX_CODE;
                end
                else
                begin
                    mode_next = LEX_SINGLE;
                end
            end
            LEX_TRIPLE:
            begin
                priority if (cur_esc)
                begin
                    esc_next = 1'b0;
                    run_next = 2'd0;
                end
                else if (is_bs)
                begin
                    esc_next = 1'b1;
                    run_next = 2'd0;
                end
                else if (is_q)
                begin
                    if (cur_run >= RUN_CLOSE)
                    begin
                        run_next  = 2'd0;
                        mode_next = LEX_CODE;
                    end
                    else
                    begin
                        run_next = cur_run + 2'd1;
                    end
                end
                else
                begin
                    run_next = 2'd0;
                end
            end
            default:
            begin
                mode_next = code_mode;
                kind_next = code_kind;
                esc_next  = 1'b0;
                run_next  = 2'd0;
            end
        endcase
    end

    // Output: code flag for this byte
    always_comb
    begin
        unique case (cur_mode)
            LEX_COMMENT: is_code = is_nl;
            LEX_OPEN1:   is_code = !is_q && !is_bs && is_nl;
            LEX_AFTER2:  is_code = !is_q && code_res;
            LEX_SINGLE:  is_code = !cur_esc && !is_bs && !is_q && is_nl;
            LEX_TRIPLE:  is_code = 1'b0;
            default:     is_code = code_res;
        endcase
    end

    // State registers advance once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= LEX_CODE;
            kind_reg <= QK_SINGLE;
            esc_reg  <= 1'b0;
            run_reg  <= 2'd0;
        end
        else if (lex_in.step)
        begin
            mode_reg <= mode_next;
            kind_reg <= kind_next;
            esc_reg  <= esc_next;
            run_reg  <= run_next;
        end
    end

`ifndef SYNTHESIS
    // Escape flag lives only inside a string body
    a_esc_in_string: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> (mode_reg == LEX_SINGLE || mode_reg == LEX_TRIPLE))
        else $error("escape pending outside a string");

    // Quote run counts only inside a triple-quoted string and never reaches three
    a_run_in_triple: assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg != 2'd0) |-> (mode_reg == LEX_TRIPLE && run_reg != 2'd3))
        else $error("quote run out of place");

    // A comment holds until a newline or a new text
    a_comment_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (lex_in.step && mode_reg == LEX_COMMENT && !lex_in.first_byte && !is_nl)
        |=> (mode_reg == LEX_COMMENT))
        else $error("comment ended early");

    // Nothing inside a triple-quoted string is code
    a_triple_masked: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == LEX_TRIPLE && !lex_in.first_byte) |-> !is_code)
        else $error("triple string byte flagged as code");
`endif

endmodule : pcsm_lexer
`default_nettype wire

/* design/python_comment_string_masker_top.sv */
// Top level of the Python comment and string masker: input stage, lexer, result register.
//
// One source byte per transaction in, one is_code bit per transaction out, in order.
// A transaction is accepted every cycle unless in_stall is high; each byte passes an input
// register, the lexer's next-state logic and a result register. The lexer state is updated
// in the same cycle the byte moves into the result register. Raise first_byte with the
// first byte of a new text to return the lexer to code mode. No configuration and no reset
// sweep.
`default_nettype none
module python_comment_string_masker_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] text_byte,
    input  wire logic       first_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            is_code
);
    import pcsm_pkg::*;

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_first_reg;
    logic       out_valid_reg, out_valid_next;
    logic       is_code_reg;
    logic       out_ready;
    logic       s1_move;
    logic       in_take;
    logic       lex_is_code;
    lex_step_t  lex_in;

    // Handshake: result register frees up when empty or taken
    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_move   = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_take   = in_valid && !in_stall;

    assign s1_valid_next  = in_take || (s1_valid_reg && !s1_move);
    assign out_valid_next = s1_move || (out_valid_reg && !out_ready);

    assign lex_in = '{step: s1_move, text_byte: s1_byte_reg, first_byte: s1_first_reg};

    pcsm_lexer u_lexer (
        .clk     (clk),
        .rst_n   (rst_n),
        .lex_in  (lex_in),
        .is_code (lex_is_code)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg  <= text_byte;
            s1_first_reg <= first_byte;
        end
        if (s1_move)
        begin
            is_code_reg <= lex_is_code;
        end
    end

    assign out_valid = out_valid_reg;
    assign is_code   = is_code_reg;

endmodule : python_comment_string_masker_top
`default_nettype wire
